// File: rtl/assert_macros.svh
// assertion macros for the rtl files, included by the rapid trigger top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AKRT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("akrt assertion failed");

// next-cycle implication, checked outside reset
`define AKRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("akrt assertion failed");

`endif

// File: rtl/akrt_pkg.sv
// types and constants of the analog key rapid trigger
package akrt_pkg;

  localparam int KEY_W        = 6;
  localparam int LEVEL_W      = 16;
  localparam int NUM_KEYS_DEF = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic {
    MODE_PLAIN = 1'b0,
    MODE_RAPID = 1'b1
  } trig_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_MODE   = 3'd0,
    REG_UPPER_POINT    = 3'd1,
    REG_LOWER_POINT    = 3'd2,
    REG_LIFT_DISTANCE  = 3'd3,
    REG_PRESS_DISTANCE = 3'd4,
    REG_NOISE_MARGIN   = 3'd5
  } cfg_reg_t;

  localparam logic [LEVEL_W-1:0] UPPER_POINT_RST    = 16'd3000;
  localparam logic [LEVEL_W-1:0] LOWER_POINT_RST    = 16'd1000;
  localparam logic [LEVEL_W-1:0] LIFT_DISTANCE_RST  = 16'd100;
  localparam logic [LEVEL_W-1:0] PRESS_DISTANCE_RST = 16'd100;
  localparam logic [LEVEL_W-1:0] NOISE_MARGIN_RST   = 16'd0;

  typedef struct packed {
    logic [KEY_W-1:0]   key_index;
    logic [LEVEL_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index_out;
    logic             pressed;
  } out_word_t;

  typedef struct packed {
    logic               triggered;
    logic               pending;
    logic               moving_down;
    logic               pressed;
    logic [LEVEL_W-1:0] tracked_level;
  } key_state_t;

  localparam int KEY_STATE_W = $bits(key_state_t);

endpackage

// File: rtl/analog_key_rapid_trigger.sv
// analog key rapid trigger: per-key press detection from analog travel samples
//
// usage
//   sample channel: one word per accepted cycle (sample_valid high, sample_stall
//   low) carrying a key index and its travel reading; lower reading = deeper
//   result channel: one word per sample, in order, with the key index and the
//   pressed state after that sample was applied
//   a sample accepted into the compute stage moves on to the result register and
//   stays valid there until taken; throughput one sample per cycle while
//   result_stall is low, set by the single read-modify-write of the key state ram per sample
//   back-to-back samples for the same key are forwarded from the last write
//   stall: with the result register full and stalled, one more sample is
//   taken into the compute stage; after that sample_stall follows result_stall
//   reset: config registers return to rapid mode, upper 3000, lower 1000,
//   lift 100, press 100, margin 0; per-key valid bits are cleared so every key
//   reads as all-zero state, no clearing pass is needed
//   config writes are taken any time but are meant for an idle block
//   keys at or beyond NUM_KEYS report released and leave no state behind
module analog_key_rapid_trigger #(
  parameter int NUM_KEYS = akrt_pkg::NUM_KEYS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     sample_valid,
  output logic                                     sample_stall,
  input  akrt_pkg::in_word_t                       sample_word,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output akrt_pkg::out_word_t                      result_word,
  input  logic                                     cfg_wr_en,
  input  logic [akrt_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [akrt_pkg::CFG_DATA_W-1:0]          cfg_data
);

  import akrt_pkg::*;

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // configuration registers
  trig_mode_t         trigger_mode;
  logic [LEVEL_W-1:0] upper_point;
  logic [LEVEL_W-1:0] lower_point;
  logic [LEVEL_W-1:0] lift_distance;
  logic [LEVEL_W-1:0] press_distance;
  logic [LEVEL_W-1:0] noise_margin;

  // compute stage
  logic               s1_valid;
  logic [KEY_W-1:0]   s1_key;
  logic [LEVEL_W-1:0] s1_sample;
  logic [AW-1:0]      s1_addr;
  logic               s1_in_range;
  logic               s1_adv;
  logic               sample_accept;

  // per-key valid bits, entry not valid reads as all zero
  logic [NUM_KEYS-1:0] key_vld;

  // last write-back, covers the read that raced it
  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  key_state_t         fwd_state;

  logic [KEY_W+AW-1:0] rd_key_ext;
  logic [KEY_W+AW-1:0] s1_key_ext;
  logic [AW-1:0]       rd_addr;
  logic [KEY_STATE_W-1:0] ram_rd_data;
  logic                ram_we;

  key_state_t cur;
  key_state_t nxt;
  logic       pressed_next;

  logic signed [LEVEL_W+1:0] m_s;
  logic signed [LEVEL_W+1:0] up_s;
  logic signed [LEVEL_W+1:0] lo_s;
  logic signed [LEVEL_W+1:0] lift_s;
  logic signed [LEVEL_W+1:0] press_s;
  logic signed [LEVEL_W+1:0] noise_s;
  logic signed [LEVEL_W+1:0] t_s;

  // handshake: compute stage drains into the result register
  assign s1_adv        = s1_valid && (!result_valid || !result_stall);
  assign sample_stall  = s1_valid && !s1_adv;
  assign sample_accept = sample_valid && !sample_stall;

  // key index widened or narrowed to the ram address
  assign rd_key_ext = {{AW{1'b0}}, sample_word.key_index};
  assign rd_addr    = rd_key_ext[AW-1:0];
  assign s1_key_ext = {{AW{1'b0}}, s1_key};
  assign s1_addr    = s1_key_ext[AW-1:0];
  assign s1_in_range = int'(s1_key) < NUM_KEYS;

  assign ram_we = s1_adv && s1_in_range;

  akrt_ram #(
    .WIDTH (KEY_STATE_W),
    .DEPTH (NUM_KEYS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_addr),
    .wr_data (nxt),
    .rd_en   (sample_accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // state as of this sample: forwarded, stored, or reset value
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      cur = fwd_state;
    end else if (s1_in_range && key_vld[s1_addr]) begin
      cur = key_state_t'(ram_rd_data);
    end else begin
      cur = '0;
    end
  end

  // key update, differences taken signed at 18 bits
  always_comb begin
    nxt     = cur;
    m_s     = signed'({2'b00, s1_sample});
    up_s    = signed'({2'b00, upper_point});
    lo_s    = signed'({2'b00, lower_point});
    lift_s  = signed'({2'b00, lift_distance});
    press_s = signed'({2'b00, press_distance});
    noise_s = signed'({2'b00, noise_margin});
    t_s     = '0;
    unique case (trigger_mode)
      MODE_RAPID: begin
        // dead zones
        if (m_s > up_s) begin
          nxt.triggered     = 1'b0;
          nxt.tracked_level = upper_point;
          nxt.pressed       = 1'b0;
          nxt.moving_down   = 1'b0;
        end else if (m_s < lo_s) begin
          nxt.triggered     = 1'b0;
          nxt.tracked_level = lower_point;
          nxt.pressed       = 1'b1;
          nxt.moving_down   = 1'b1;
        end
        t_s = signed'({2'b00, nxt.tracked_level});
        // inside the band: follow travel, re-trigger on reversal
        if (nxt.triggered) begin
          if (nxt.pending) begin
            if ((m_s - t_s) >= lift_s) begin
              nxt.pending = 1'b0;
              nxt.pressed = 1'b0;
            end else if ((t_s - m_s) >= press_s) begin
              nxt.pending = 1'b0;
              nxt.pressed = 1'b1;
            end
          end else if ((m_s > t_s) && ((m_s - t_s) > noise_s) && nxt.moving_down) begin
            nxt.pending     = 1'b1;
            nxt.moving_down = 1'b0;
          end else begin
            nxt.tracked_level = s1_sample;
          end
        end
        // entering the band
        if (!nxt.triggered && (m_s >= lo_s) && (m_s <= up_s)) begin
          nxt.triggered   = 1'b1;
          nxt.pressed     = 1'b1;
          nxt.pending     = 1'b0;
          nxt.moving_down = !nxt.moving_down;
        end
      end
      MODE_PLAIN: begin
        nxt.pressed = (up_s - m_s) > noise_s;
      end
      default: begin
        nxt = cur;
      end
    endcase
    pressed_next = s1_in_range && nxt.pressed;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      fwd_valid    <= 1'b0;
      key_vld      <= '0;
    end else begin
      if (sample_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (ram_we) begin
        fwd_valid        <= 1'b1;
        key_vld[s1_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (sample_accept) begin
      s1_key    <= sample_word.key_index;
      s1_sample <= sample_word.sample;
    end
    if (s1_adv) begin
      result_word.key_index_out <= s1_key;
      result_word.pressed       <= pressed_next;
    end
    if (ram_we) begin
      fwd_addr  <= s1_addr;
      fwd_state <= nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_mode   <= MODE_RAPID;
      upper_point    <= UPPER_POINT_RST;
      lower_point    <= LOWER_POINT_RST;
      lift_distance  <= LIFT_DISTANCE_RST;
      press_distance <= PRESS_DISTANCE_RST;
      noise_margin   <= NOISE_MARGIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRIGGER_MODE:   trigger_mode   <= trig_mode_t'(cfg_data[0]);
        REG_UPPER_POINT:    upper_point    <= cfg_data;
        REG_LOWER_POINT:    lower_point    <= cfg_data;
        REG_LIFT_DISTANCE:  lift_distance  <= cfg_data;
        REG_PRESS_DISTANCE: press_distance <= cfg_data;
        REG_NOISE_MARGIN:   noise_margin   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // checks
`include "assert_macros.svh"

  // keys beyond the table always report released
  `AKRT_ASSERT_NOW(a_oob_released, clk, rst,
    result_valid && (int'(result_word.key_index_out) >= NUM_KEYS), !result_word.pressed)
  // a finished word lands in the result register
  `AKRT_ASSERT_NEXT(a_adv_result, clk, rst, s1_adv, result_valid)
  // an accepted word occupies the compute stage next cycle
  `AKRT_ASSERT_NEXT(a_accept_s1, clk, rst, sample_accept, s1_valid)

endmodule

// File: rtl/akrt_ram.sv
// generic single-write, single-read ram with registered read data
module akrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: tb/sv/analog_key_rapid_trigger_test.sv
// testbench of the analog key rapid trigger, with its own model of every key
`timescale 1ns / 100ps

module analog_key_rapid_trigger_test;
  import akrt_pkg::*;

  localparam int KEYS        = NUM_KEYS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  in_word_t              sample_word = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_word_t             result_word;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  analog_key_rapid_trigger i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // model copy of the shared settings, reset values as after rst
  trig_mode_t         mode_cfg   = MODE_RAPID;
  logic [LEVEL_W-1:0] upper_cfg  = UPPER_POINT_RST;
  logic [LEVEL_W-1:0] lower_cfg  = LOWER_POINT_RST;
  logic [LEVEL_W-1:0] lift_cfg   = LIFT_DISTANCE_RST;
  logic [LEVEL_W-1:0] press_cfg  = PRESS_DISTANCE_RST;
  logic [LEVEL_W-1:0] margin_cfg = NOISE_MARGIN_RST;

  // model copy of the per-key state, all keys start cleared
  logic               key_trig  [KEYS];
  logic               key_pend  [KEYS];
  logic               key_down  [KEYS];
  logic               key_press [KEYS];
  logic [LEVEL_W-1:0] key_track [KEYS];

  // travel position of each key for the random walks
  int                 walk_level [KEYS];

  out_word_t expected_states[$];
  bit        idle_en      = 1'b1;
  int        fail_cnt     = 0;
  int        sent_cnt     = 0;
  int        checked_cnt  = 0;
  int        pressed_cnt  = 0;
  int        setting_cnt  = 0;
  int        cycle_cnt    = 0;

  initial begin
    for (int k = 0; k < KEYS; k++) begin
      key_trig[k]   = 1'b0;
      key_pend[k]   = 1'b0;
      key_down[k]   = 1'b0;
      key_press[k]  = 1'b0;
      key_track[k]  = '0;
      walk_level[k] = 0;
    end
  end

  initial begin
    forever #2 clk = ~clk;
  end

  // pressed state of one key after one sample, updating the model state
  function automatic out_word_t predict_key_state(input in_word_t w);
    out_word_t res;
    int        k;
    int        m;
    int        up;
    int        lo;
    int        t;
    k  = int'(w.key_index);
    m  = int'(w.sample);
    up = int'(upper_cfg);
    lo = int'(lower_cfg);
    res.key_index_out = w.key_index;
    res.pressed       = 1'b0;
    if (k < KEYS) begin
      if (mode_cfg == MODE_RAPID) begin
        // dead zones first: release above the upper point, press below the lower
        if (m > up) begin
          key_trig[k]  = 1'b0;
          key_track[k] = upper_cfg;
          key_press[k] = 1'b0;
          key_down[k]  = 1'b0;
        end else if (m < lo) begin
          key_trig[k]  = 1'b0;
          key_track[k] = lower_cfg;
          key_press[k] = 1'b1;
          key_down[k]  = 1'b1;
        end
        if (key_trig[k]) begin
          t = int'(key_track[k]);
          if (key_pend[k]) begin
            // a pending reversal resolves by lift or by press distance
            if (m - t >= int'(lift_cfg)) begin
              key_pend[k]  = 1'b0;
              key_press[k] = 1'b0;
            end else if (t - m >= int'(press_cfg)) begin
              key_pend[k]  = 1'b0;
              key_press[k] = 1'b1;
            end
          end else if (m > t && (m - t) > int'(margin_cfg) && key_down[k]) begin
            // upward reversal beyond the noise margin arms the key
            key_pend[k] = 1'b1;
            key_down[k] = ~key_down[k];
          end else begin
            key_track[k] = w.sample;
          end
        end
        // entering the band untriggered counts as a press
        if (!key_trig[k] && m >= lo && m <= up) begin
          key_trig[k]  = 1'b1;
          key_press[k] = 1'b1;
          key_pend[k]  = 1'b0;
          key_down[k]  = ~key_down[k];
        end
      end else begin
        // plain threshold, rapid flags untouched
        key_press[k] = (up - m) > int'(margin_cfg);
      end
      res.pressed = key_press[k];
    end
    return res;
  endfunction

  // send one sample word and queue the state it should report
  task automatic send_sample(input logic [KEY_W-1:0] key, input logic [LEVEL_W-1:0] level);
    in_word_t w;
    w.key_index = key;
    w.sample    = level;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_word  <= w;
    // inputs only move on rising edges, so the falling edge sees the final stall
    forever begin
      @(negedge clk);
      if (!sample_stall) break;
    end
    @(posedge clk);
    expected_states.push_back(predict_key_state(w));
    sent_cnt++;
  endtask

  // stop sending and let every outstanding word come back
  task automatic wait_drain();
    sample_valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write all six registers on an idle block
  task automatic set_config(input trig_mode_t mode, input logic [LEVEL_W-1:0] up,
                            input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] lift,
                            input logic [LEVEL_W-1:0] press, input logic [LEVEL_W-1:0] margin);
    cfg_reg_t regs[6];
    logic [CFG_DATA_W-1:0] vals[6];
    wait_drain();
    regs = '{REG_TRIGGER_MODE, REG_UPPER_POINT, REG_LOWER_POINT,
             REG_LIFT_DISTANCE, REG_PRESS_DISTANCE, REG_NOISE_MARGIN};
    vals = '{{15'd0, mode}, up, lo, lift, press, margin};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en  <= 1'b0;
    mode_cfg   = mode;
    upper_cfg  = up;
    lower_cfg  = lo;
    lift_cfg   = lift;
    press_cfg  = press;
    margin_cfg = margin;
    for (int k = 0; k < KEYS; k++) walk_level[k] = int'(up);
    setting_cnt++;
  endtask

  function automatic logic [LEVEL_W-1:0] pick_distance();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom_range(1, 1500));
    endcase
  endfunction

  // random settings, now and then an inverted band or extreme distances
  task automatic randomize_config(input trig_mode_t mode);
    logic [LEVEL_W-1:0] up;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] margin;
    up = LEVEL_W'($urandom_range(500, 65000));
    if ($urandom_range(0, 5) == 0) lo = LEVEL_W'($urandom_range(int'(up), 65535));
    else lo = LEVEL_W'($urandom_range(0, int'(up)));
    case ($urandom_range(0, 9))
      0:       margin = '0;
      1:       margin = '1;
      default: margin = LEVEL_W'($urandom_range(0, 300));
    endcase
    set_config(mode, up, lo, pick_distance(), pick_distance(), margin);
  endtask

  // one step of a key's travel: mostly small moves, some jumps near the band edges or to any level
  task automatic send_walk_step(input bit all_keys);
    int k;
    int lvl;
    int span;
    int edge_lvl;
    k = all_keys ? $urandom_range(0, KEYS - 1) : $urandom_range(0, 5);
    span = int'(lift_cfg);
    if (int'(press_cfg) > span) span = int'(press_cfg);
    if (int'(margin_cfg) > span) span = int'(margin_cfg);
    span = span + 20;
    if (span > 3000) span = 3000;
    case ($urandom_range(0, 19))
      0: lvl = $urandom_range(0, 65535);
      1, 2: begin
        edge_lvl = $urandom_range(0, 1) ? int'(upper_cfg) : int'(lower_cfg);
        lvl = edge_lvl + int'($urandom_range(0, 2 * span)) - span;
      end
      default: lvl = walk_level[k] + int'($urandom_range(0, 2 * span)) - span;
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 65535) lvl = 65535;
    walk_level[k] = lvl;
    send_sample(KEY_W'(k), LEVEL_W'(lvl));
  endtask

  // rapid mode at reset settings: release, band entry, tracking, reversal, lift, bottom
  task automatic test_rapid_directed();
    send_sample(6'd0, 16'd3500);
    send_sample(6'd0, 16'd2500);
    send_sample(6'd0, 16'd2400);
    send_sample(6'd0, 16'd2450);
    send_sample(6'd0, 16'd2550);
    send_sample(6'd0, 16'd2400);
    send_sample(6'd0, 16'd900);
    send_sample(6'd0, 16'd0);
    send_sample(6'd0, 16'd65535);
    send_sample(6'd63, 16'd0);
    send_sample(6'd63, 16'd65535);
    send_sample(6'd42, 16'd3000);
    send_sample(6'd42, 16'd1000);
  endtask

  // plain threshold right at the margin, and a sample above the upper point
  task automatic test_plain_directed();
    set_config(MODE_PLAIN, 16'd3000, 16'd1000, 16'd100, 16'd100, 16'd200);
    send_sample(6'd5, 16'd2800);
    send_sample(6'd5, 16'd2799);
    send_sample(6'd5, 16'd0);
    send_sample(6'd5, 16'd65535);
  endtask

  // lower point above upper point; key 0 still carries its rapid flags from before
  task automatic test_inverted_band();
    set_config(MODE_RAPID, 16'd1000, 16'd3000, 16'd100, 16'd100, 16'd0);
    send_sample(6'd0, 16'd2000);
    send_sample(6'd0, 16'd500);
    send_sample(6'd0, 16'd3500);
    send_sample(6'd0, 16'd1000);
  endtask

  // widest band with zero distances and full margin, then a band of one point
  task automatic test_config_extremes();
    set_config(MODE_RAPID, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    send_sample(6'd1, 16'hffff);
    send_sample(6'd1, 16'h0000);
    send_sample(6'd1, 16'h8000);
    set_config(MODE_RAPID, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h0000);
    send_sample(6'd1, 16'h0000);
    send_sample(6'd1, 16'h0001);
  endtask

  // random settings per phase, key travel as random walks, idling on both sides
  task automatic test_random_walks();
    for (int ph = 0; ph < 7; ph++) begin
      randomize_config((ph == 2 || ph == 5) ? MODE_PLAIN : MODE_RAPID);
      repeat (95) send_walk_step(ph[0]);
    end
  endtask

  // back-to-back words with no idling, same keys hit repeatedly
  task automatic test_full_rate();
    randomize_config(MODE_RAPID);
    idle_en = 1'b0;
    repeat (80) send_walk_step(1'b0);
  endtask

  // result side stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // compare each taken result word with the oldest expected state
  always @(negedge clk) begin : check_result
    out_word_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      checked_cnt++;
      if (expected_states.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result word: key %0d pressed %0b",
                   result_word.key_index_out, result_word.pressed);
      end else begin
        want = expected_states.pop_front();
        if (result_word.pressed === 1'b1) pressed_cnt++;
        if (result_word.key_index_out !== want.key_index_out ||
            result_word.pressed !== want.pressed) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: expected key %0d pressed %0b, got key %0d pressed %0b",
                     want.key_index_out, want.pressed,
                     result_word.key_index_out, result_word.pressed);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_rapid_directed();
    test_plain_directed();
    test_inverted_band();
    test_config_extremes();
    test_random_walks();
    test_full_rate();
    wait_drain();
    if (expected_states.size() != 0) fail_cnt++;
    $display("sent %0d samples over %0d register settings, %0d results checked, %0d pressed",
             sent_cnt, setting_cnt, checked_cnt, pressed_cnt);
    $display("covered plain and rapid modes, inverted band, extreme settings, %0d mismatches",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
